// ===== rtl/srat_pkg.sv =====
// Shared types and constants of the section region address translator.
// No dependencies; every rtl file imports this package.
package srat_pkg;

  // Default region table depth
  localparam int MAX_SECTIONS_DEF = 16;

  // Rvas below this and below the image size map to themselves when no region covers them
  localparam logic [31:0] HEADER_GUARD = 32'h0000_1000;

  // Configuration register indexes
  localparam logic CFG_IMAGE_SIZE    = 1'b0;
  localparam logic CFG_SECTION_COUNT = 1'b1;

  // Request actions
  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_RVA    = 2'd1,
    ACT_OFFSET = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Full request as registered at the input
  typedef struct packed {
    action_t     action;
    logic [3:0]  idx;
    logic [31:0] vbase;
    logic [31:0] vsize;
    logic [31:0] raw_off;
    logic [31:0] raw_len;
    logic        readable;
    logic [31:0] addr;
    logic [31:0] len;
  } req_t;

  // Part of a request that travels past the table lookup
  typedef struct packed {
    action_t     action;
    logic [31:0] addr;
    logic [31:0] len;
  } carry_t;

  // One table entry, span ends precomputed at write time
  typedef struct packed {
    logic [31:0] vbase;
    logic [32:0] span_end;
    logic [31:0] raw_off;
    logic [32:0] raw_end;
    logic [31:0] raw_len;
    logic        readable;
  } entry_t;

  // Fields of the first matching entry
  typedef struct packed {
    logic        found;
    logic [31:0] vbase;
    logic [32:0] span_end;
    logic [31:0] raw_off;
    logic [31:0] raw_len;
    logic        readable;
  } sel_t;

endpackage

// ===== rtl/srat_table.sv =====
// Region table: entry storage, parallel span compare and first-match select.
// Depends on srat_pkg.
module srat_table import srat_pkg::*; #(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [4:0] sec_count,
  input  logic       s1_vld,
  input  req_t       s1_req,
  output logic       s3_vld,
  output carry_t     s3_carry,
  output sel_t       s3_sel
);

  entry_t                  tbl_r [MAX_SECTIONS];
  entry_t                  new_ent;
  logic [MAX_SECTIONS-1:0] hit_nxt;
  logic [MAX_SECTIONS-1:0] s2_hit_r;
  logic [MAX_SECTIONS-1:0] first;
  logic                    s2_vld_r;
  carry_t                  s2_carry_r;
  sel_t                    sel_nxt;
  logic                    s3_vld_r;
  carry_t                  s3_carry_r;
  sel_t                    s3_sel_r;

  // Entry image for a write request
  always_comb begin
    new_ent.vbase    = s1_req.vbase;
    new_ent.span_end = {1'b0, s1_req.vbase} +
                       {1'b0, (s1_req.vsize > s1_req.raw_len) ? s1_req.vsize
                                                              : s1_req.raw_len};
    new_ent.raw_off  = s1_req.raw_off;
    new_ent.raw_end  = {1'b0, s1_req.raw_off} + {1'b0, s1_req.raw_len};
    new_ent.raw_len  = s1_req.raw_len;
    new_ent.readable = s1_req.readable;
  end

  // Table write; slots beyond the table are dropped
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_SECTIONS; i++) begin
      if (s1_vld && (s1_req.action == ACT_WRITE) && (int'(s1_req.idx) == i)) begin
        tbl_r[i] <= new_ent;
      end
    end
  end

  // Stage 1: every active lane compares the address against its span
  always_comb begin
    logic [32:0] a;
    logic        vcov;
    logic        ocov;
    a = {1'b0, s1_req.addr};
    for (int i = 0; i < MAX_SECTIONS; i++) begin
      vcov = (a >= {1'b0, tbl_r[i].vbase}) && (a < tbl_r[i].span_end);
      ocov = (a >= {1'b0, tbl_r[i].raw_off}) && (a < tbl_r[i].raw_end);
      hit_nxt[i] = (int'(sec_count) > i) &&
                   (((s1_req.action == ACT_RVA) && vcov) ||
                    ((s1_req.action == ACT_OFFSET) && ocov));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_hit_r          <= hit_nxt;
    s2_carry_r.action <= s1_req.action;
    s2_carry_r.addr   <= s1_req.addr;
    s2_carry_r.len    <= s1_req.len;
  end

  // Stage 2: lowest-index hit, then AND-OR pick of its fields
  assign first = s2_hit_r & (~s2_hit_r + MAX_SECTIONS'(1));

  always_comb begin
    sel_nxt       = '0;
    sel_nxt.found = |s2_hit_r;
    for (int i = 0; i < MAX_SECTIONS; i++) begin
      sel_nxt.vbase    = sel_nxt.vbase    | ({32{first[i]}} & tbl_r[i].vbase);
      sel_nxt.span_end = sel_nxt.span_end | ({33{first[i]}} & tbl_r[i].span_end);
      sel_nxt.raw_off  = sel_nxt.raw_off  | ({32{first[i]}} & tbl_r[i].raw_off);
      sel_nxt.raw_len  = sel_nxt.raw_len  | ({32{first[i]}} & tbl_r[i].raw_len);
      sel_nxt.readable = sel_nxt.readable | (first[i] & tbl_r[i].readable);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_carry_r <= s2_carry_r;
    s3_sel_r   <= sel_nxt;
  end

  assign s3_vld   = s3_vld_r;
  assign s3_carry = s3_carry_r;
  assign s3_sel   = s3_sel_r;

endmodule

// ===== rtl/srat_calc.sv =====
// Translation arithmetic: offsets, probe, fallback, then image bound checks.
// Depends on srat_pkg.
module srat_calc import srat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] image_size,
  input  logic        s3_vld,
  input  carry_t      s3_carry,
  input  sel_t        s3_sel,
  output logic        out_valid,
  output logic        out_mapped,
  output logic [32:0] out_translated,
  output logic [31:0] out_readable_bytes,
  output logic        out_probe_ok,
  output logic        out_read_in_bounds
);

  logic        s4_vld_r;
  action_t     s4_action_r;
  logic        s4_mapped_r,  s4_mapped_nxt;
  logic [32:0] s4_trans_r,   s4_trans_nxt;
  logic        s4_found_r;
  logic [31:0] s4_left_r,    s4_left_nxt;
  logic        s4_probe_r,   s4_probe_nxt;
  logic [31:0] s4_len_r;

  logic        out_valid_r;
  logic        out_mapped_r,   out_mapped_nxt;
  logic [32:0] out_trans_r,    out_trans_nxt;
  logic [31:0] out_rbytes_r,   out_rbytes_nxt;
  logic        out_probe_r,    out_probe_nxt;
  logic        out_inb_r,      out_inb_nxt;

  // Stage 3: region-relative offset and translation
  always_comb begin
    logic [31:0] delta;
    logic [31:0] odelta;
    logic        fallback;
    delta         = s3_carry.addr - s3_sel.vbase;
    odelta        = s3_carry.addr - s3_sel.raw_off;
    fallback      = (s3_carry.addr < image_size) && (s3_carry.addr < HEADER_GUARD);
    s4_mapped_nxt = 1'b0;
    s4_trans_nxt  = '0;
    s4_left_nxt   = s3_sel.raw_len - delta;
    s4_probe_nxt  = 1'b0;
    case (s3_carry.action)
      ACT_RVA: begin
        if (s3_sel.found) begin
          if (delta < s3_sel.raw_len) begin
            s4_mapped_nxt = 1'b1;
            s4_trans_nxt  = {1'b0, s3_sel.raw_off} + {1'b0, delta};
          end
          s4_probe_nxt = s3_sel.readable &&
                         (({1'b0, s3_carry.addr} + {1'b0, s3_carry.len}) <=
                          s3_sel.span_end);
        end else if (fallback) begin
          s4_mapped_nxt = 1'b1;
          s4_trans_nxt  = {1'b0, s3_carry.addr};
        end
      end
      ACT_OFFSET: begin
        if (s3_sel.found) begin
          s4_mapped_nxt = 1'b1;
          s4_trans_nxt  = {1'b0, s3_sel.vbase} + {1'b0, odelta};
        end
      end
      default: begin
        s4_mapped_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    s4_action_r <= s3_carry.action;
    s4_mapped_r <= s4_mapped_nxt;
    s4_trans_r  <= s4_trans_nxt;
    s4_found_r  <= s3_sel.found;
    s4_left_r   <= s4_left_nxt;
    s4_probe_r  <= s4_probe_nxt;
    s4_len_r    <= s3_carry.len;
  end

  // Stage 4: readable byte count and bounded read against the image
  always_comb begin
    logic [32:0] img;
    logic [32:0] room;
    logic [32:0] avail;
    img            = {1'b0, image_size};
    room           = img - s4_trans_r;
    avail          = room;
    out_mapped_nxt = s4_mapped_r;
    out_trans_nxt  = s4_trans_r;
    out_rbytes_nxt = '0;
    out_probe_nxt  = 1'b0;
    out_inb_nxt    = 1'b0;
    if (s4_action_r == ACT_RVA) begin
      out_probe_nxt = s4_probe_r;
      if (s4_mapped_r) begin
        if (s4_found_r && ({1'b0, s4_left_r} < room)) begin
          avail = {1'b0, s4_left_r};
        end
        if (s4_trans_r < img) begin
          out_rbytes_nxt = avail[31:0];
        end
        out_inb_nxt = (s4_trans_r <= img) && ({1'b0, s4_len_r} <= room);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_mapped_r <= out_mapped_nxt;
    out_trans_r  <= out_trans_nxt;
    out_rbytes_r <= out_rbytes_nxt;
    out_probe_r  <= out_probe_nxt;
    out_inb_r    <= out_inb_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_mapped         = out_mapped_r;
  assign out_translated     = out_trans_r;
  assign out_readable_bytes = out_rbytes_r;
  assign out_probe_ok       = out_probe_r;
  assign out_read_in_bounds = out_inb_r;

endmodule

// ===== rtl/section_region_address_translator_core.sv =====
// A request passes the input, s2, s3, s4 and output registers before its result strobe.
// Throughput: one request per cycle; busy is never raised, set by the five-register pipeline.
// Every request, table writes included, returns one result; the receiver cannot stall.
// Reset (synchronous, rst_n low) clears config registers and stage valids; the region
// table has no reset and is undefined until written. Depends on srat_pkg, srat_table, srat_calc.
module section_region_address_translator_core import srat_pkg::*; #(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_entry_index,
  input  logic [31:0] in_entry_virtual_base,
  input  logic [31:0] in_entry_virtual_size,
  input  logic [31:0] in_entry_raw_offset,
  input  logic [31:0] in_entry_raw_size,
  input  logic        in_entry_readable,
  input  logic [31:0] in_address,
  input  logic [31:0] in_length,
  // result channel
  output logic        out_valid,
  output logic        out_mapped,
  output logic [32:0] out_translated,
  output logic [31:0] out_readable_bytes,
  output logic        out_probe_ok,
  output logic        out_read_in_bounds,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic        accept;
  logic [31:0] image_size_r;
  logic [4:0]  sec_count_r;
  logic        s1_vld_r;
  req_t        s1_req_r;
  logic        s3_vld;
  carry_t      s3_carry;
  sel_t        s3_sel;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r <= '0;
      sec_count_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_SIZE:    image_size_r <= cfg_wdata;
        CFG_SECTION_COUNT: sec_count_r  <= cfg_wdata[4:0];
        default:           image_size_r <= image_size_r;
      endcase
    end
  end

  // Input register stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_req_r.action   <= action_t'(in_action);
    s1_req_r.idx      <= in_entry_index;
    s1_req_r.vbase    <= in_entry_virtual_base;
    s1_req_r.vsize    <= in_entry_virtual_size;
    s1_req_r.raw_off  <= in_entry_raw_offset;
    s1_req_r.raw_len  <= in_entry_raw_size;
    s1_req_r.readable <= in_entry_readable;
    s1_req_r.addr     <= in_address;
    s1_req_r.len      <= in_length;
  end

  // Region lookup
  srat_table #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .sec_count (sec_count_r),
    .s1_vld    (s1_vld_r),
    .s1_req    (s1_req_r),
    .s3_vld    (s3_vld),
    .s3_carry  (s3_carry),
    .s3_sel    (s3_sel)
  );

  // Translation and bound checks
  srat_calc u_calc (
    .clk                (clk),
    .rst_n              (rst_n),
    .image_size         (image_size_r),
    .s3_vld             (s3_vld),
    .s3_carry           (s3_carry),
    .s3_sel             (s3_sel),
    .out_valid          (out_valid),
    .out_mapped         (out_mapped),
    .out_translated     (out_translated),
    .out_readable_bytes (out_readable_bytes),
    .out_probe_ok       (out_probe_ok),
    .out_read_in_bounds (out_read_in_bounds)
  );

  // Each result strobe belongs to a request accepted at the input, registered through the pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4) &&
     $past(rst_n, 5)) |->
    (out_valid == $past(accept, 5)))
    else $error("result strobe does not match request accepted five edges earlier");

  // An unmapped result carries no offset, byte count or bounded read
  a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_mapped) |->
    ((out_translated == '0) && (out_readable_bytes == '0) && !out_read_in_bounds))
    else $error("unmapped result has nonzero translation fields");

  // Readable bytes never run past the end of the image
  a_rbytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_readable_bytes != '0)) |->
    (({1'b0, out_readable_bytes} + out_translated) <= {2'b00, image_size_r}))
    else $error("readable byte count exceeds image size");

endmodule
